[rtl/core/obm_pkg.sv]
`default_nettype none

package obm_pkg;

  localparam int unsigned TICK_W = 10;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRES_WAIT     = 3'd1,
    CFG_PRES_LOW      = 3'd2,
    CFG_WRITE_SLOT    = 3'd3,
    CFG_READ_SAMPLE   = 3'd4,
    CFG_READ_TAIL     = 3'd5
  } cfg_idx_e;

  // Command codes; code 3 means nothing and is ignored.
  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [9:0] RST_LOW_DEFAULT     = 10'd750;
  localparam logic [7:0] PRES_WAIT_DEFAULT   = 8'd200;
  localparam logic [7:0] PRES_LOW_DEFAULT    = 8'd240;
  localparam logic [6:0] WRITE_SLOT_DEFAULT  = 7'd60;
  localparam logic [5:0] READ_SAMPLE_DEFAULT = 6'd8;
  localparam logic [6:0] READ_TAIL_DEFAULT   = 7'd60;

  localparam logic [TICK_W-1:0] RELEASE_WAIT_TICKS = TICK_W'(15);
  localparam logic [TICK_W-1:0] WRITE_LOW_TICKS    = TICK_W'(1);
  localparam logic [TICK_W-1:0] READ_LOW_TICKS     = TICK_W'(2);
  localparam logic [2:0]        LAST_BIT           = 3'd7;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] presence_wait_limit;
    logic [7:0] presence_low_limit;
    logic [6:0] write_slot_ticks;
    logic [5:0] read_sample_ticks;
    logic [6:0] read_tail_ticks;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] op;
    logic [7:0] tx_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       line_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_presence;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/obm_cfg_regs.sv]
`default_nettype none

module obm_cfg_regs
  import obm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_en_i,
  input  wire logic [2:0] wr_index_i,
  input  wire logic [9:0] wr_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks     <= RST_LOW_DEFAULT;
      cfg_q.presence_wait_limit <= PRES_WAIT_DEFAULT;
      cfg_q.presence_low_limit  <= PRES_LOW_DEFAULT;
      cfg_q.write_slot_ticks    <= WRITE_SLOT_DEFAULT;
      cfg_q.read_sample_ticks   <= READ_SAMPLE_DEFAULT;
      cfg_q.read_tail_ticks     <= READ_TAIL_DEFAULT;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_RESET_LOW:   cfg_q.reset_low_ticks     <= wr_data_i;
        CFG_PRES_WAIT:   cfg_q.presence_wait_limit <= wr_data_i[7:0];
        CFG_PRES_LOW:    cfg_q.presence_low_limit  <= wr_data_i[7:0];
        CFG_WRITE_SLOT:  cfg_q.write_slot_ticks    <= wr_data_i[6:0];
        CFG_READ_SAMPLE: cfg_q.read_sample_ticks   <= wr_data_i[5:0];
        CFG_READ_TAIL:   cfg_q.read_tail_ticks     <= wr_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/obm_seq.sv]
`default_nettype none

module obm_seq
  import obm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  output result_t    res_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_PRES_HIGH,
    PH_PRES_LOW,
    PH_WR_LOW,
    PH_WR_BIT,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_TAIL
  } phase_e;

  phase_e              ph_q, ph_d;
  op_e                 op_q, op_d;
  logic [TICK_W-1:0]   tc_q, tc_d, tc_inc, lim;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic [7:0]          rx_q, rx_d;
  logic                fail_q, fail_d;
  logic                hit, done, drive;

  assign tc_inc = tc_q + TICK_W'(1);

  // Limit of the running phase; a limit of zero is met at once.
  always_comb begin
    case (ph_q)
      PH_RST_LOW:   lim = cfg_i.reset_low_ticks;
      PH_RST_WAIT:  lim = RELEASE_WAIT_TICKS;
      PH_PRES_HIGH: lim = TICK_W'(cfg_i.presence_wait_limit);
      PH_PRES_LOW:  lim = TICK_W'(cfg_i.presence_low_limit);
      PH_WR_LOW:    lim = WRITE_LOW_TICKS;
      PH_WR_BIT:    lim = TICK_W'(cfg_i.write_slot_ticks);
      PH_RD_LOW:    lim = READ_LOW_TICKS;
      PH_RD_WAIT:   lim = TICK_W'(cfg_i.read_sample_ticks);
      PH_RD_TAIL:   lim = TICK_W'(cfg_i.read_tail_ticks);
      default:      lim = '0;
    endcase
  end

  assign hit = (tc_inc >= lim);

  always_comb begin
    ph_d    = ph_q;
    op_d    = op_q;
    tc_d    = tc_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    rx_d    = rx_q;
    fail_d  = fail_q;
    done    = 1'b0;

    if (item_i.kind == KIND_CMD) begin
      if (ph_q == PH_IDLE) begin
        case (item_i.op)
          OP_RESET: begin
            op_d  = OP_RESET;
            bit_d = '0;
            tc_d  = '0;
            ph_d  = PH_RST_LOW;
          end
          OP_WRITE: begin
            op_d    = OP_WRITE;
            bit_d   = '0;
            tc_d    = '0;
            shift_d = item_i.tx_byte;
            ph_d    = PH_WR_LOW;
          end
          OP_READ: begin
            op_d    = OP_READ;
            bit_d   = '0;
            tc_d    = '0;
            shift_d = '0;
            ph_d    = PH_RD_LOW;
          end
          default: ;
        endcase
      end
    end else begin
      case (ph_q)
        PH_RST_LOW, PH_RST_WAIT, PH_WR_LOW, PH_RD_LOW: begin
          tc_d = tc_inc;
          if (hit) begin
            tc_d = '0;
            case (ph_q)
              PH_RST_LOW:  ph_d = PH_RST_WAIT;
              PH_RST_WAIT: ph_d = PH_PRES_HIGH;
              PH_WR_LOW:   ph_d = PH_WR_BIT;
              default:     ph_d = PH_RD_WAIT;
            endcase
          end
        end
        PH_PRES_HIGH: begin
          if (item_i.line_level) begin
            tc_d = tc_inc;
            if (hit) begin
              fail_d = 1'b1;
              done   = 1'b1;
            end
          end else begin
            // The first low tick already counts toward the low limit.
            ph_d = PH_PRES_LOW;
            tc_d = TICK_W'(1);
            if (TICK_W'(cfg_i.presence_low_limit) <= TICK_W'(1)) begin
              fail_d = 1'b1;
              done   = 1'b1;
            end
          end
        end
        PH_PRES_LOW: begin
          if (!item_i.line_level) begin
            tc_d = tc_inc;
            if (hit) begin
              fail_d = 1'b1;
              done   = 1'b1;
            end
          end else begin
            fail_d = 1'b0;
            done   = 1'b1;
          end
        end
        PH_WR_BIT: begin
          tc_d = tc_inc;
          if (hit) begin
            shift_d = {1'b0, shift_q[7:1]};
            if (bit_q == LAST_BIT) begin
              done = 1'b1;
            end else begin
              bit_d = bit_q + 3'd1;
              tc_d  = '0;
              ph_d  = PH_WR_LOW;
            end
          end
        end
        PH_RD_WAIT: begin
          tc_d = tc_inc;
          if (hit) begin
            shift_d = {item_i.line_level, shift_q[7:1]};
            tc_d    = '0;
            ph_d    = PH_RD_TAIL;
          end
        end
        PH_RD_TAIL: begin
          tc_d = tc_inc;
          if (hit) begin
            if (bit_q == LAST_BIT) begin
              rx_d = shift_q;
              done = 1'b1;
            end else begin
              bit_d = bit_q + 3'd1;
              tc_d  = '0;
              ph_d  = PH_RD_LOW;
            end
          end
        end
        default: ;
      endcase
      if (done) begin
        ph_d = PH_IDLE;
        tc_d = '0;
      end
    end
  end

  // Line drive for the coming microsecond follows the new phase.
  always_comb begin
    case (ph_d)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = 1'b0;
      PH_WR_BIT:                        drive = shift_d[0];
      default:                          drive = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      op_q    <= OP_RESET;
      tc_q    <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      rx_q    <= '0;
      fail_q  <= 1'b0;
    end else if (step_i) begin
      ph_q    <= ph_d;
      op_q    <= op_d;
      tc_q    <= tc_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
      fail_q  <= fail_d;
    end
  end

  assign res_o.line_drive  = drive;
  assign res_o.busy_res    = (ph_d != PH_IDLE);
  assign res_o.done_res    = done;
  assign res_o.rx_byte     = rx_d;
  assign res_o.no_presence = fail_d;

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> ph_q == PH_IDLE)
    else $error("finished operation did not return to idle");

  a_write_phase_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_WR_LOW || ph_q == PH_WR_BIT) |-> op_q == OP_WRITE)
    else $error("write slot running without a write command");

  a_read_phase_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_RD_LOW || ph_q == PH_RD_WAIT || ph_q == PH_RD_TAIL)
    |-> op_q == OP_READ)
    else $error("read slot running without a read command");

  a_idle_tick_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ph_q == PH_IDLE && item_i.kind == KIND_TICK |=> ph_q == PH_IDLE)
    else $error("tick while idle started an operation");

endmodule

`default_nettype wire

[rtl/core/onewire_bus_master_unit.sv]
// One-wire bus master.
// The input channel takes words that are either a command (kind 0: op 0 bus
// reset with presence check, op 1 write tx_byte, op 2 read a byte) or a
// one-microsecond tick (kind 1) that carries the sampled bus level. Every
// accepted word yields exactly one result word on the output channel: the
// line drive for the coming microsecond, busy and done flags, the byte of
// the last completed read and the presence status of the last bus reset.
// A command that arrives while an operation runs, or carries op code 3, is
// ignored but still answered with a status word.
// Timing registers are written through the configuration port, by index in
// the order reset_low, presence_wait, presence_low, write_slot, read_sample,
// read_tail; writes are taken in any cycle and should be made while idle.
// A word accepted into the input register is processed by the sequencer once
// the output register is empty or being drained, and its result is then
// registered in the output register. Throughput is one word per cycle while
// the receiver takes every result, with one sequencer step per word between
// the two registers. When the receiver stalls, the output register holds its
// word and the input register takes one more word before input ready drops.
// Reset idles the sequencer, clears rx_byte and the presence flag, and loads
// the register defaults.
`default_nettype none

module onewire_bus_master_unit
  import obm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       line_level_i,

  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            line_drive_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      rx_byte_o,
  output logic            no_presence_o,

  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [9:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t res, out_res_q;
  logic    out_valid_q;
  logic    advance;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  obm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // A held word is processed when the output register is empty or being
  // drained in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q.kind       <= kind_i;
      in_item_q.op         <= op_i;
      in_item_q.tx_byte    <= tx_byte_i;
      in_item_q.line_level <= line_level_i;
    end
  end

  obm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_drive_o  = out_res_q.line_drive;
  assign busy_res_o    = out_res_q.busy_res;
  assign done_res_o    = out_res_q.done_res;
  assign rx_byte_o     = out_res_q.rx_byte;
  assign no_presence_o = out_res_q.no_presence;

endmodule

`default_nettype wire

[dv/onewire_bus_master_unit_tb.sv]
`timescale 1ns / 1ps

module onewire_bus_master_unit_tb;
  import obm_pkg::*;

  // Command code 3 carries no operation, and register indexes 6 and 7 select
  // no register. Both are legal on the ports, so they are driven on purpose.
  localparam logic [1:0] OP_SPARE     = 2'd3;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 4;

  // Sequencer phases of the predictor.
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_RST_LOW,
    SEQ_RST_WAIT,
    SEQ_PRES_HIGH,
    SEQ_PRES_LOW,
    SEQ_WR_LOW,
    SEQ_WR_BIT,
    SEQ_RD_LOW,
    SEQ_RD_WAIT,
    SEQ_RD_TAIL
  } seq_phase_e;

  typedef logic [9:0] reg_set_t [6];

  // One row of the directed table: the word to send and, where the answer is
  // plain at a glance, the status word typed in by hand.
  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } step_row_t;

  localparam result_t IDLE_WORD = '{line_drive: 1'b1, busy_res: 1'b0, done_res: 1'b0,
                                    rx_byte: 8'h00, no_presence: 1'b0};
  // A bus reset that gives up waiting for presence finishes with the flag set.
  localparam result_t NO_PRES_WORD = '{line_drive: 1'b1, busy_res: 1'b0, done_res: 1'b1,
                                       rx_byte: 8'h00, no_presence: 1'b1};
  localparam item_t TICK_LO = '{kind: KIND_TICK, op: OP_RESET, tx_byte: 8'h00,
                                line_level: 1'b0};
  localparam item_t TICK_HI = '{kind: KIND_TICK, op: OP_RESET, tx_byte: 8'h00,
                                line_level: 1'b1};

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       kind = KIND_TICK;
  logic [1:0] op = OP_RESET;
  logic [7:0] tx_byte = 8'h00;
  logic       line_level = 1'b1;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       line_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       no_presence;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = CFG_RESET_LOW;
  logic [9:0] cfg_data = '0;

  // Predictor state: a copy of the master's sequencer and its timing registers.
  cfg_t        timing = '{reset_low_ticks: RST_LOW_DEFAULT,
                          presence_wait_limit: PRES_WAIT_DEFAULT,
                          presence_low_limit: PRES_LOW_DEFAULT,
                          write_slot_ticks: WRITE_SLOT_DEFAULT,
                          read_sample_ticks: READ_SAMPLE_DEFAULT,
                          read_tail_ticks: READ_TAIL_DEFAULT};
  seq_phase_e  sq_phase = SEQ_IDLE;
  logic [9:0]  sq_ticks = '0;
  logic [2:0]  sq_bit = '0;
  logic [7:0]  sq_shift = '0;
  logic        sq_no_pres = 1'b0;
  logic [7:0]  sq_rx_last = '0;

  // How the slave will answer the next bus reset: high ticks before it pulls
  // the line low, and the length of its presence pulse.
  int unsigned pres_high_plan = 0;
  int unsigned pres_low_plan = 1;

  result_t     pending_status [$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  int unsigned hold_left = 0;

  step_row_t   dir_rows [26];

  onewire_bus_master_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .op_i         (op),
    .tx_byte_i    (tx_byte),
    .line_level_i (line_level),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .line_drive_o (line_drive),
    .busy_res_o   (busy_res),
    .done_res_o   (done_res),
    .rx_byte_o    (rx_byte),
    .no_presence_o(no_presence),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog. A correct run ends far below this count, so hitting it means the
  // block has hung or lost words.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d status words outstanding", $time,
               pending_status.size());
      $display("FAIL onewire_bus_master_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor of the bus master
  // ---------------------------------------------------------------------------

  function automatic void enter_seq(seq_phase_e nxt);
    sq_phase = nxt;
    sq_ticks = '0;
  endfunction

  // Counts one more tick and tells whether the limit is reached. A limit of
  // zero is reached on the first tick, exactly like a limit of one.
  function automatic logic tick_hits(logic [9:0] lim);
    sq_ticks = sq_ticks + 10'd1;
    return sq_ticks >= lim;
  endfunction

  // Applies one input word to the predictor and returns the status word the
  // master must answer with.
  function automatic result_t master_step(item_t it);
    logic    fin;
    result_t r;
    fin = 1'b0;
    if (it.kind == KIND_CMD) begin
      // Commands start an operation only from idle; anything else is dropped.
      if (sq_phase == SEQ_IDLE && it.op != OP_SPARE) begin
        sq_bit = '0;
        case (it.op)
          OP_RESET: enter_seq(SEQ_RST_LOW);
          OP_WRITE: begin
            sq_shift = it.tx_byte;
            enter_seq(SEQ_WR_LOW);
          end
          default: begin
            sq_shift = '0;
            enter_seq(SEQ_RD_LOW);
          end
        endcase
      end
    end else begin
      case (sq_phase)
        SEQ_RST_LOW:
          if (tick_hits(timing.reset_low_ticks)) enter_seq(SEQ_RST_WAIT);
        SEQ_RST_WAIT:
          if (tick_hits(RELEASE_WAIT_TICKS)) enter_seq(SEQ_PRES_HIGH);
        SEQ_PRES_HIGH:
          if (it.line_level) begin
            if (tick_hits(10'(timing.presence_wait_limit))) begin
              sq_no_pres = 1'b1;
              fin = 1'b1;
            end
          end else begin
            // The first low tick already counts toward the pulse length.
            enter_seq(SEQ_PRES_LOW);
            if (tick_hits(10'(timing.presence_low_limit))) begin
              sq_no_pres = 1'b1;
              fin = 1'b1;
            end
          end
        SEQ_PRES_LOW:
          if (!it.line_level) begin
            if (tick_hits(10'(timing.presence_low_limit))) begin
              sq_no_pres = 1'b1;
              fin = 1'b1;
            end
          end else begin
            sq_no_pres = 1'b0;
            fin = 1'b1;
          end
        SEQ_WR_LOW:
          if (tick_hits(WRITE_LOW_TICKS)) enter_seq(SEQ_WR_BIT);
        SEQ_WR_BIT:
          if (tick_hits(10'(timing.write_slot_ticks))) begin
            sq_shift = sq_shift >> 1;
            if (sq_bit >= LAST_BIT) begin
              fin = 1'b1;
            end else begin
              sq_bit = sq_bit + 3'd1;
              enter_seq(SEQ_WR_LOW);
            end
          end
        SEQ_RD_LOW:
          if (tick_hits(READ_LOW_TICKS)) enter_seq(SEQ_RD_WAIT);
        SEQ_RD_WAIT:
          if (tick_hits(10'(timing.read_sample_ticks))) begin
            sq_shift = {it.line_level, sq_shift[7:1]};
            enter_seq(SEQ_RD_TAIL);
          end
        SEQ_RD_TAIL:
          if (tick_hits(10'(timing.read_tail_ticks))) begin
            if (sq_bit >= LAST_BIT) begin
              sq_rx_last = sq_shift;
              fin = 1'b1;
            end else begin
              sq_bit = sq_bit + 3'd1;
              enter_seq(SEQ_RD_LOW);
            end
          end
        default: ;
      endcase
      if (fin) enter_seq(SEQ_IDLE);
    end

    case (sq_phase)
      SEQ_RST_LOW, SEQ_WR_LOW, SEQ_RD_LOW: r.line_drive = 1'b0;
      SEQ_WR_BIT:                          r.line_drive = sq_shift[0];
      default:                             r.line_drive = 1'b1;
    endcase
    r.busy_res    = (sq_phase != SEQ_IDLE);
    r.done_res    = fin;
    r.rx_byte     = sq_rx_last;
    r.no_presence = sq_no_pres;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Picks the next word from the predictor's view of the master. Most traffic
  // is well formed: commands from idle and ticks while busy, with the slave's
  // presence answer shaped so that most resets pass and some time out.
  // Commands while busy, unused op codes and idle ticks are the noise.
  function automatic item_t next_word();
    item_t       it;
    int unsigned wait_lim;
    int unsigned low_lim;
    it.kind       = KIND_TICK;
    it.op         = 2'($urandom_range(3));
    it.tx_byte    = 8'($urandom_range(255));
    it.line_level = 1'($urandom_range(1));
    if (sq_phase == SEQ_IDLE) begin
      if ($urandom_range(99) < 70) begin
        it.kind = KIND_CMD;
        it.op   = ($urandom_range(99) < 8) ? OP_SPARE : 2'($urandom_range(2));
        if (it.op == OP_RESET) begin
          wait_lim = (timing.presence_wait_limit == 0) ? 1 : timing.presence_wait_limit;
          low_lim  = (timing.presence_low_limit == 0) ? 1 : timing.presence_low_limit;
          pres_high_plan = ($urandom_range(99) < 85) ? $urandom_range(wait_lim - 1)
                                                      : wait_lim + $urandom_range(3);
          pres_low_plan  = ($urandom_range(99) < 85) ? $urandom_range(low_lim, 1)
                                                      : low_lim + $urandom_range(3);
        end
      end
    end else if ($urandom_range(99) < 6) begin
      it.kind = KIND_CMD;
    end else begin
      case (sq_phase)
        SEQ_PRES_HIGH: it.line_level = (sq_ticks < pres_high_plan);
        SEQ_PRES_LOW:  it.line_level = (sq_ticks >= pres_low_plan);
        default: ;
      endcase
    end
    return it;
  endfunction

  // Offers one word, waits for the handshake, then books the status word the
  // master owes for it. Valid stays high between back-to-back words; it only
  // drops when an idle gap is drawn.
  task automatic send_word(input item_t it, input logic typed, input result_t want);
    int unsigned gap;
    result_t     guess;
    gap = 0;
    if (hold_left == 0 && !hold_go) begin
      while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    kind       <= it.kind;
    op         <= it.op;
    tx_byte    <= it.tx_byte;
    line_level <= it.line_level;
    do @(posedge clk_i); while (!in_ready);
    guess = master_step(it);
    pending_status.push_back(typed ? want : guess);
  endtask

  // Lets the running operation finish, then holds the input off until every
  // owed status word has come back.
  task automatic finish_and_drain();
    while (sq_phase != SEQ_IDLE) send_word(next_word(), 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register writes keep valid high from one write to the next and drop it
  // only after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_RESET_LOW:   timing.reset_low_ticks     = val;
      CFG_PRES_WAIT:   timing.presence_wait_limit = val[7:0];
      CFG_PRES_LOW:    timing.presence_low_limit  = val[7:0];
      CFG_WRITE_SLOT:  timing.write_slot_ticks    = val[6:0];
      CFG_READ_SAMPLE: timing.read_sample_ticks   = val[5:0];
      CFG_READ_TAIL:   timing.read_tail_ticks     = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input reg_set_t vals, input bit with_spare);
    cfg_idx_e idx;
    idx = idx.first();
    do begin
      write_reg(idx, vals[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    if (with_spare) begin
      write_reg(CFG_SPARE_LO, 10'h3FF);
      write_reg(CFG_SPARE_HI, 10'h000);
    end
    cfg_valid <= 1'b0;
  endtask

  // One random phase. Every word but a command that the master ignores counts
  // toward the budget. When asked, the receiver is told halfway through to
  // hold off for a long stretch while words keep coming, so both registers
  // fill and input ready drops.
  task automatic run_phase(input int unsigned budget, input int unsigned send_pct,
                           input int unsigned recv_pct, input bit with_hold);
    int unsigned sent;
    bit          held;
    bit          counts;
    item_t       it;
    sent = 0;
    held = 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (sent < budget) begin
      if (with_hold && !held && sent >= budget / 2) begin
        hold_go = 1'b1;
        held = 1'b1;
      end
      it = next_word();
      counts = !(it.kind == KIND_CMD && (sq_phase != SEQ_IDLE || it.op == OP_SPARE));
      send_word(it, 1'b0, '0);
      if (counts) sent++;
    end
    finish_and_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // Output ready follows the stall rate of the current phase, except during a
  // requested hold, which is counted down here in cycles.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Each status word taken from the master is matched against the oldest one
  // still owed.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $display("%0t ns: status word with none expected, expected nothing, got %h",
                 $time, {line_drive, busy_res, done_res, rx_byte, no_presence});
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("line_drive", want.line_drive, line_drive);
        check_field("busy_res", want.busy_res, busy_res);
        check_field("done_res", want.done_res, done_res);
        check_field("rx_byte", want.rx_byte, rx_byte);
        check_field("no_presence", want.no_presence, no_presence);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    reg_set_t mixed;

    // Directed words, run with every timing register at its minimum so that
    // a whole bus reset fits. The reset sees the line low on its first
    // presence tick and, with a pulse limit of one, gives up at once.
    dir_rows = '{
      '{TICK_LO, 1'b1, IDLE_WORD},
      '{TICK_HI, 1'b1, IDLE_WORD},
      '{'{KIND_CMD, OP_SPARE, 8'hFF, 1'b1}, 1'b1, IDLE_WORD},
      '{'{KIND_CMD, OP_RESET, 8'h00, 1'b0}, 1'b0, '0},
      '{'{KIND_CMD, OP_WRITE, 8'hFF, 1'b1}, 1'b0, '0},
      '{TICK_HI, 1'b0, '0}, '{TICK_LO, 1'b0, '0}, '{TICK_HI, 1'b0, '0},
      '{TICK_HI, 1'b0, '0}, '{TICK_LO, 1'b0, '0}, '{TICK_HI, 1'b0, '0},
      '{TICK_HI, 1'b0, '0}, '{TICK_HI, 1'b0, '0}, '{TICK_LO, 1'b0, '0},
      '{TICK_HI, 1'b0, '0}, '{TICK_HI, 1'b0, '0}, '{TICK_HI, 1'b0, '0},
      '{TICK_LO, 1'b0, '0}, '{TICK_HI, 1'b0, '0}, '{TICK_HI, 1'b0, '0},
      '{TICK_HI, 1'b0, '0},
      '{TICK_LO, 1'b1, NO_PRES_WORD},
      '{'{KIND_CMD, OP_WRITE, 8'hFF, 1'b0}, 1'b0, '0},
      '{'{KIND_CMD, OP_READ, 8'h00, 1'b1}, 1'b0, '0},
      '{TICK_HI, 1'b0, '0},
      '{TICK_LO, 1'b0, '0}
    };

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    apply_setting('{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1}, 1'b0);
    foreach (dir_rows[i]) send_word(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    finish_and_drain();

    // Short timings, no idling on either side.
    apply_setting('{10'd3, 10'd4, 10'd4, 10'd2, 10'd3, 10'd2}, 1'b0);
    run_phase(100, 0, 0, 1'b0);

    // All registers at zero, which behaves as one; the sender mostly idles.
    // The unused register indexes are written here as well.
    apply_setting('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b1);
    run_phase(80, 88, 0, 1'b0);

    // Longer slots with a receiver that mostly stalls.
    apply_setting('{10'd6, 10'd12, 10'd10, 10'd5, 10'd4, 10'd6}, 1'b0);
    run_phase(90, 0, 88, 1'b0);

    // Minimum timings, both sides idling, and one long receiver hold.
    apply_setting('{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1}, 1'b0);
    run_phase(100, 35, 35, 1'b1);

    // A random small setting.
    foreach (mixed[i]) mixed[i] = 10'($urandom_range(12));
    apply_setting(mixed, 1'b0);
    run_phase(80, 35, 35, 1'b0);

    // All data bits set: every register lands at its maximum. Operations are
    // long here, so the run ends with the first one still going and only the
    // owed status words are collected.
    apply_setting('{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF}, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (30) send_word(next_word(), 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("PASS onewire_bus_master_unit");
    end else begin
      $display("FAIL onewire_bus_master_unit");
    end
    $finish;
  end

endmodule
